[design/ker_pkg.sv]
// Package for the key edge and typematic repeat unit.
// Shared widths, register indexes and the per-key state types.
// No dependencies.
package ker_pkg;

	localparam int SLOT_W       = 7;
	localparam int CFG_W        = 8;
	localparam int CNT_W        = 8;
	localparam int CFG_IDX_W    = 1;
	localparam int ADDR_MAX_W   = 8;     // enough for up to 256 keys
	localparam int KEY_COUNT_DEF = 128;

	localparam logic [CFG_W-1:0] FIRST_DELAY_RST   = 8'd30;
	localparam logic [CFG_W-1:0] NEXT_INTERVAL_RST = 8'd5;

	localparam logic [CFG_IDX_W-1:0] REG_FIRST_DELAY   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NEXT_INTERVAL = 1'd1;

	// per-key state word
	typedef struct packed {
		logic             pressed;
		logic [CNT_W-1:0] count;
	} entry_t;

	// write request from the update logic to the state memory
	typedef struct packed {
		logic                  en;
		logic [ADDR_MAX_W-1:0] addr;
		entry_t                data;
	} wr_req_t;

endpackage

[design/ker_sample_if.sv]
// Input channel of the key edge and typematic repeat unit: one key sample per word.
// Depends on ker_pkg.
interface ker_sample_if;
	logic                        valid;
	logic                        ready;
	logic [ker_pkg::SLOT_W-1:0]  key_slot;
	logic                        pressed;

	modport source(output valid, output key_slot, output pressed, input ready);
	modport sink(input valid, input key_slot, input pressed, output ready);
endinterface

[design/ker_result_if.sv]
// Output channel of the key edge and typematic repeat unit: one key status per word.
// No dependencies.
interface ker_result_if;
	logic valid;
	logic ready;
	logic held;
	logic press_edge;
	logic release_edge;
	logic repeat_pulse;

	modport source(output valid, output held, output press_edge, output release_edge,
		output repeat_pulse, input ready);
	modport sink(input valid, input held, input press_edge, input release_edge,
		input repeat_pulse, output ready);
endinterface

[design/ker_key_mem.sv]
// Per-key state memory: one read and one write port, registered read data,
// reset valid bits and a same-cycle write-to-read bypass. Depends on ker_pkg.
module ker_key_mem #(
	parameter int DEPTH = ker_pkg::KEY_COUNT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             rd_en,
	input  logic [ker_pkg::ADDR_MAX_W-1:0]   rd_addr,
	output ker_pkg::entry_t                  rd_data,
	input  ker_pkg::wr_req_t                 wr
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	ker_pkg::entry_t mem [DEPTH];
	ker_pkg::entry_t rd_data_q;
	ker_pkg::entry_t fwd_data_q;
	logic [DEPTH-1:0] vld_q;
	logic             rd_vld_q;
	logic             fwd_q;

	logic [IDX_W-1:0] rd_idx;
	logic [IDX_W-1:0] wr_idx;

	assign rd_idx = rd_addr[IDX_W-1:0];
	assign wr_idx = wr.addr[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr_idx] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q  <= mem[rd_idx];
			fwd_data_q <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
			fwd_q    <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_idx];
				// write landing on the entry being read in the same cycle
				fwd_q    <= wr.en && (wr_idx == rd_idx);
			end
		end
	end

	// entries never written since reset read as zero
	assign rd_data = fwd_q ? fwd_data_q : (rd_vld_q ? rd_data_q : '0);

endmodule

[design/key_edge_and_typematic_repeat_unit.sv]
// Key edge detect and typematic auto-repeat. Takes one key sample per word and
// returns one status word per sample (held, press/release edge, repeat pulse).
// Throughput is one sample per clock, also for back-to-back samples of the same
// key. A status word is presented from the output register once its sample leaves
// stage 1. The per-key state is read from memory at acceptance and written back
// when the sample leaves stage 1, with a bypass when the next sample reads the key
// being written. A stalled result holds stage 1, which then holds back the input.
// Per-key state is cleared at reset through valid bits, so the block is ready right
// out of reset. Configuration writes must be done while the block is idle.
module key_edge_and_typematic_repeat_unit #(
	parameter int KEY_COUNT = ker_pkg::KEY_COUNT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	ker_sample_if.sink                         sample,
	ker_result_if.source                       result,
	input  logic                               cfg_write,
	input  logic [ker_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ker_pkg::CFG_W-1:0]          cfg_data
);

	logic [ker_pkg::CFG_W-1:0] first_delay_q;
	logic [ker_pkg::CFG_W-1:0] next_interval_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_delay_q   <= ker_pkg::FIRST_DELAY_RST;
			next_interval_q <= ker_pkg::NEXT_INTERVAL_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				ker_pkg::REG_FIRST_DELAY:   first_delay_q   <= cfg_data;
				ker_pkg::REG_NEXT_INTERVAL: next_interval_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input side
	logic                            accept;
	logic [ker_pkg::ADDR_MAX_W-1:0]  slot_ext;
	logic                            in_range;

	assign slot_ext = {{(ker_pkg::ADDR_MAX_W-ker_pkg::SLOT_W){1'b0}}, sample.key_slot};
	assign in_range = {1'b0, slot_ext} < (ker_pkg::ADDR_MAX_W+1)'(KEY_COUNT);
	assign accept   = sample.valid && sample.ready;

	// stage 1: memory read data arrives
	logic                            v_s1;
	logic                            ok_s1;
	logic                            now_s1;
	logic [ker_pkg::ADDR_MAX_W-1:0]  addr_s1;
	logic                            adv;
	logic                            out_v_q;

	assign adv          = v_s1 && (!out_v_q || result.ready);
	assign sample.ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (sample.ready) begin
			v_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_s1   <= in_range;
			now_s1  <= sample.pressed;
			addr_s1 <= slot_ext;
		end
	end

	ker_pkg::entry_t  ent;
	ker_pkg::wr_req_t wr;

	ker_key_mem #(
		.DEPTH(KEY_COUNT)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (slot_ext),
		.rd_data (ent),
		.wr      (wr)
	);

	// update
	logic [ker_pkg::CNT_W-1:0] reload;
	logic [ker_pkg::CNT_W-1:0] cnt_nxt;
	logic                      pulse;

	always_comb begin
		reload = (!ent.pressed && (first_delay_q != '0)) ? first_delay_q : next_interval_q;
		pulse  = 1'b0;
		if (now_s1) begin
			// counter would reach zero or below after this frame's decrement
			if (ent.count <= ker_pkg::CNT_W'(1)) begin
				cnt_nxt = reload;
				pulse   = 1'b1;
			end else begin
				cnt_nxt = ent.count - ker_pkg::CNT_W'(1);
			end
		end else begin
			cnt_nxt = '0;
		end
	end

	assign wr.en           = adv && ok_s1;
	assign wr.addr         = addr_s1;
	assign wr.data.pressed = now_s1;
	assign wr.data.count   = cnt_nxt;

	// output register
	logic held_q;
	logic press_q;
	logic release_q;
	logic pulse_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= 1'b1;
		end else if (result.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			held_q    <= ok_s1 && now_s1;
			press_q   <= ok_s1 && now_s1 && !ent.pressed;
			release_q <= ok_s1 && !now_s1 && ent.pressed;
			pulse_q   <= ok_s1 && pulse;
		end
	end

	assign result.valid        = out_v_q;
	assign result.held         = held_q;
	assign result.press_edge   = press_q;
	assign result.release_edge = release_q;
	assign result.repeat_pulse = pulse_q;

endmodule
